### src/bdlp_pkg.sv
// bdlp_pkg: shared types and constants for the button debounce / long-press block
// request payload structs, per-button status struct, config register indexes
// no dependencies
`default_nettype none
package bdlp_pkg;

  localparam int unsigned FIELD_W = 3;
  localparam int unsigned CNT_W   = 16;
  localparam int unsigned CFG_W   = 16;
  localparam int unsigned IDX_W   = 1;

  localparam logic [IDX_W-1:0] REG_LONG_PRESS_TICKS = 1'b0;
  localparam logic [IDX_W-1:0] REG_REPEAT_TICKS     = 1'b1;

  localparam logic [CNT_W-1:0] LONG_PRESS_RESET = 16'd200;
  localparam logic [CNT_W-1:0] REPEAT_RESET     = 16'd50;

  typedef struct packed {
    logic [FIELD_W-1:0] raw_levels;
    logic [FIELD_W-1:0] clear_hold_mask;
  } in_req_t;

  typedef struct packed {
    logic [FIELD_W-1:0] pressed_mask;
    logic [FIELD_W-1:0] long_mask;
    logic [FIELD_W-1:0] hold_mask;
  } out_req_t;

  typedef struct packed {
    logic pressed;
    logic long_flag;
    logic hold_flag;
  } btn_status_t;

endpackage
`default_nettype wire

### src/bdlp_button.sv
// bdlp_button: state of one button: three-sample debounce, press and repeat counters
// gives the status after the update as combinational next values
// depends on bdlp_pkg
`default_nettype none
module bdlp_button (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       step,
  input  wire logic                       sample,
  input  wire logic                       clear_hold,
  input  wire logic [bdlp_pkg::CNT_W-1:0] long_press_ticks,
  input  wire logic [bdlp_pkg::CNT_W-1:0] repeat_ticks,
  output bdlp_pkg::btn_status_t           status_nxt
);

  logic                       prev_one_r, prev_one_nxt;
  logic                       prev_two_r, prev_two_nxt;
  logic                       deb_r, deb_nxt;
  logic [bdlp_pkg::CNT_W-1:0] press_r, press_nxt;
  logic [bdlp_pkg::CNT_W-1:0] rep_r, rep_nxt;
  logic                       long_r, long_nxt;
  logic                       hold_r, hold_nxt;
  logic [bdlp_pkg::CNT_W:0]   rep_inc;

  assign rep_inc = {1'b0, rep_r} + {{bdlp_pkg::CNT_W{1'b0}}, 1'b1};

  always_comb begin
    prev_two_nxt = prev_one_r;
    prev_one_nxt = sample;
    deb_nxt      = ((sample == prev_one_r) && (sample == prev_two_r)) ? sample : deb_r;
    press_nxt    = press_r;
    rep_nxt      = rep_r;
    long_nxt     = long_r;
    hold_nxt     = clear_hold ? 1'b0 : hold_r;
    if (!deb_nxt) begin
      if (press_r < long_press_ticks) begin
        press_nxt = press_r + {{(bdlp_pkg::CNT_W-1){1'b0}}, 1'b1};
      end else begin
        long_nxt = 1'b1;
        if (rep_r < repeat_ticks) begin
          // count reaches the period exactly here since it was below it
          if (rep_inc >= {1'b0, repeat_ticks}) begin
            rep_nxt  = '0;
            hold_nxt = 1'b1;
          end else begin
            rep_nxt = rep_inc[bdlp_pkg::CNT_W-1:0];
          end
        end
      end
    end else begin
      press_nxt = '0;
      rep_nxt   = '0;
      long_nxt  = 1'b0;
      hold_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_one_r <= 1'b1;
      prev_two_r <= 1'b1;
      deb_r      <= 1'b1;
      press_r    <= '0;
      rep_r      <= '0;
      long_r     <= 1'b0;
      hold_r     <= 1'b0;
    end else if (step) begin
      prev_one_r <= prev_one_nxt;
      prev_two_r <= prev_two_nxt;
      deb_r      <= deb_nxt;
      press_r    <= press_nxt;
      rep_r      <= rep_nxt;
      long_r     <= long_nxt;
      hold_r     <= hold_nxt;
    end
  end

  assign status_nxt.pressed   = ~deb_nxt;
  assign status_nxt.long_flag = long_nxt;
  assign status_nxt.hold_flag = hold_nxt;

endmodule
`default_nettype wire

### src/button_debounce_long_press_repeat.sv
// button_debounce_long_press_repeat: top level, input register, button cells, result register
// depends on bdlp_pkg and bdlp_button
//
// usage: one request on in_* per timer tick carries the active-low raw pin levels and a
// mask of hold flags to clear. each request yields exactly one result on out_*: the
// debounced pressed mask, the long-press mask and the hold-repeat mask after the tick.
// a request goes into an input register; when it steps, all button cells update their
// state in one pass and the masks land in the result register, which sets out_valid.
// throughput is one request per cycle unless a held result stalls it; the per-button
// update (one 16-bit compare and increment per counter) is the whole path.
// when out_ready is low the result register holds, the input register fills, and
// in_ready drops only once both are full; nothing is lost or repeated.
// reset (synchronous, rst_n low) marks all buttons released, clears counters and
// flags, empties both registers and loads long_press_ticks = 200, repeat_ticks = 50.
// cfg_we writes register cfg_index (0 long_press_ticks, 1 repeat_ticks) at once;
// write only while no request is in flight.
// NUM_BUTTONS sets the number of button cells; fields carry buttons 0 to 2, cells above
// that see a pressed level and are not reported.
//
`default_nettype none
module button_debounce_long_press_repeat #(
  parameter int unsigned NUM_BUTTONS = 3
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire bdlp_pkg::in_req_t          in_data,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output bdlp_pkg::out_req_t              out_data,
  input  wire logic                       cfg_we,
  input  wire logic [bdlp_pkg::IDX_W-1:0] cfg_index,
  input  wire logic [bdlp_pkg::CFG_W-1:0] cfg_wdata
);

  logic                       in_v_r;
  bdlp_pkg::in_req_t          in_data_r;
  logic                       step;
  logic [bdlp_pkg::CNT_W-1:0] long_press_ticks_r;
  logic [bdlp_pkg::CNT_W-1:0] repeat_ticks_r;
  bdlp_pkg::btn_status_t      status [NUM_BUTTONS];
  bdlp_pkg::out_req_t         result_nxt;

  assign step     = in_v_r && (!out_valid || out_ready);
  assign in_ready = !in_v_r || step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      long_press_ticks_r <= bdlp_pkg::LONG_PRESS_RESET;
      repeat_ticks_r     <= bdlp_pkg::REPEAT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        bdlp_pkg::REG_LONG_PRESS_TICKS: long_press_ticks_r <= cfg_wdata;
        bdlp_pkg::REG_REPEAT_TICKS:     repeat_ticks_r     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ready) begin
      in_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_data_r <= in_data;
    end
  end

  for (genvar i = 0; i < NUM_BUTTONS; i++) begin : g_btn
    logic sample;
    logic clear_hold;
    if (i < bdlp_pkg::FIELD_W) begin : g_in
      assign sample     = in_data_r.raw_levels[i];
      assign clear_hold = in_data_r.clear_hold_mask[i];
    end else begin : g_none
      // no field bit for this button: reads as pressed, no clear
      assign sample     = 1'b0;
      assign clear_hold = 1'b0;
    end
    bdlp_button u_btn (
      .clk              (clk),
      .rst_n            (rst_n),
      .step             (step),
      .sample           (sample),
      .clear_hold       (clear_hold),
      .long_press_ticks (long_press_ticks_r),
      .repeat_ticks     (repeat_ticks_r),
      .status_nxt       (status[i])
    );
  end

  always_comb begin
    result_nxt = '0;
    for (int unsigned i = 0; i < bdlp_pkg::FIELD_W; i++) begin
      if (i < NUM_BUTTONS) begin
        result_nxt.pressed_mask[i] = status[i].pressed;
        result_nxt.long_mask[i]    = status[i].long_flag;
        result_nxt.hold_mask[i]    = status[i].hold_flag;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_data <= result_nxt;
    end
  end

endmodule
`default_nettype wire

### tb/button_debounce_long_press_repeat_tb.sv
`timescale 1ns / 1ps
// button_debounce_long_press_repeat_tb: self-checking bench for the debounce / long-press block
// predicts every tick's pressed, long and hold masks and checks them against out_*
// depends on bdlp_pkg and button_debounce_long_press_repeat
module button_debounce_long_press_repeat_tb;

  localparam int NUM_BTN     = bdlp_pkg::FIELD_W;
  localparam int CFG_BITS    = bdlp_pkg::CFG_W;
  localparam int CYCLE_LIMIT = 200000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  bdlp_pkg::in_req_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  bdlp_pkg::out_req_t out_data;
  logic cfg_we = 1'b0;
  logic [bdlp_pkg::IDX_W-1:0] cfg_index = bdlp_pkg::REG_LONG_PRESS_TICKS;
  logic [bdlp_pkg::CFG_W-1:0] cfg_wdata = '0;

  button_debounce_long_press_repeat #(.NUM_BUTTONS(NUM_BTN)) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always #6 clk = ~clk;

  // shadow of the block's per-button state and registers
  logic [NUM_BTN-1:0] btn_s1 = '1;
  logic [NUM_BTN-1:0] btn_s2 = '1;
  logic [NUM_BTN-1:0] btn_level = '1;
  logic [NUM_BTN-1:0] btn_long = '0;
  logic [NUM_BTN-1:0] btn_hold = '0;
  logic [bdlp_pkg::CNT_W-1:0] btn_press_cnt [NUM_BTN] = '{default: '0};
  logic [bdlp_pkg::CNT_W-1:0] btn_rep_cnt [NUM_BTN] = '{default: '0};
  logic [bdlp_pkg::CFG_W-1:0] lp_ticks = bdlp_pkg::LONG_PRESS_RESET;
  logic [bdlp_pkg::CFG_W-1:0] rep_ticks = bdlp_pkg::REPEAT_RESET;

  bdlp_pkg::out_req_t expected_masks[$];
  int error_count = 0;
  int cycle_count = 0;

  int send_gap_pct = 0;
  int recv_gap_pct = 0;
  int hold_off_len = 0;
  logic hold_off_req = 1'b0;
  logic hold_off_ack = 1'b0;
  int hold_off_left = 0;
  logic [NUM_BTN-1:0] stim_level = '1;

  function automatic bdlp_pkg::out_req_t debounce_tick(bdlp_pkg::in_req_t req);
    bdlp_pkg::out_req_t res;
    logic s;
    res = '0;
    for (int b = 0; b < NUM_BTN; b++) begin
      s = req.raw_levels[b];
      if (req.clear_hold_mask[b]) btn_hold[b] = 1'b0;
      // level only moves after three equal samples
      if (s == btn_s1[b] && s == btn_s2[b]) btn_level[b] = s;
      btn_s2[b] = btn_s1[b];
      btn_s1[b] = s;
      if (!btn_level[b]) begin
        if (btn_press_cnt[b] < lp_ticks) begin
          btn_press_cnt[b] = btn_press_cnt[b] + 1'b1;
        end else begin
          btn_long[b] = 1'b1;
          // a count already at or past the period stays frozen
          if (btn_rep_cnt[b] < rep_ticks) begin
            btn_rep_cnt[b] = btn_rep_cnt[b] + 1'b1;
            if (btn_rep_cnt[b] >= rep_ticks) begin
              btn_rep_cnt[b] = '0;
              btn_hold[b] = 1'b1;
            end
          end
        end
      end else begin
        btn_press_cnt[b] = '0;
        btn_rep_cnt[b] = '0;
        btn_long[b] = 1'b0;
        btn_hold[b] = 1'b0;
      end
      res.pressed_mask[b] = ~btn_level[b];
      res.long_mask[b] = btn_long[b];
      res.hold_mask[b] = btn_hold[b];
    end
    return res;
  endfunction

  // result side: random ready, long hold-off on request, field checks
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_masks.size() == 0) begin
          $error("result with no request waiting: %0h", out_data);
          error_count++;
        end else begin
          bdlp_pkg::out_req_t exp_res;
          exp_res = expected_masks.pop_front();
          if (out_data.pressed_mask !== exp_res.pressed_mask) begin
            $error("pressed_mask: expected %0h, actual %0h",
                   exp_res.pressed_mask, out_data.pressed_mask);
            error_count++;
          end
          if (out_data.long_mask !== exp_res.long_mask) begin
            $error("long_mask: expected %0h, actual %0h",
                   exp_res.long_mask, out_data.long_mask);
            error_count++;
          end
          if (out_data.hold_mask !== exp_res.hold_mask) begin
            $error("hold_mask: expected %0h, actual %0h",
                   exp_res.hold_mask, out_data.hold_mask);
            error_count++;
          end
        end
      end
      if (hold_off_req != hold_off_ack) begin
        hold_off_ack <= hold_off_req;
        hold_off_left <= hold_off_len;
        out_ready <= 1'b0;
      end else if (hold_off_left != 0) begin
        hold_off_left <= hold_off_left - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_gap_pct);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic send_request(input bdlp_pkg::in_req_t req);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_masks.push_back(debounce_tick(req));
  endtask

  task automatic send_ticks(input logic [bdlp_pkg::FIELD_W-1:0] raw,
                            input logic [bdlp_pkg::FIELD_W-1:0] clr, input int n);
    bdlp_pkg::in_req_t req;
    req.raw_levels = raw;
    req.clear_hold_mask = clr;
    repeat (n) send_request(req);
  endtask

  // stop offering and let every outstanding result come back
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_masks.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic retune(input logic [bdlp_pkg::CFG_W-1:0] lp,
                        input logic [bdlp_pkg::CFG_W-1:0] rp);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_index <= bdlp_pkg::REG_LONG_PRESS_TICKS;
    cfg_wdata <= lp;
    @(posedge clk);
    cfg_index <= bdlp_pkg::REG_REPEAT_TICKS;
    cfg_wdata <= rp;
    @(posedge clk);
    cfg_we <= 1'b0;
    lp_ticks = lp;
    rep_ticks = rp;
  endtask

  // mostly held levels with rare flips, some glitches and some pure noise
  task automatic random_burst(input int n, input int flip_permille);
    bdlp_pkg::in_req_t req;
    for (int k = 0; k < n; k++) begin
      for (int b = 0; b < NUM_BTN; b++)
        if ($urandom_range(0, 999) < flip_permille) stim_level[b] = ~stim_level[b];
      if ($urandom_range(0, 9) == 0)
        req.raw_levels = NUM_BTN'($urandom_range(0, 7));
      else if ($urandom_range(0, 29) == 0)
        req.raw_levels = stim_level ^ NUM_BTN'($urandom_range(1, 7));
      else
        req.raw_levels = stim_level;
      req.clear_hold_mask = ($urandom_range(0, 7) == 0) ? NUM_BTN'($urandom_range(0, 7))
                                                        : '0;
      send_request(req);
    end
  endtask

  task automatic test_debounce_glitch();
    send_ticks(3'b111, 3'b000, 2);
    // two low samples are not enough to register a press
    send_ticks(3'b110, 3'b000, 2);
    send_ticks(3'b111, 3'b000, 1);
  endtask

  task automatic test_long_press_and_hold();
    retune(16'd2, 16'd2);
    send_ticks(3'b000, 3'b000, 6);
    send_ticks(3'b000, 3'b111, 1);
    send_ticks(3'b000, 3'b101, 2);
    send_ticks(3'b000, 3'b010, 1);
    send_ticks(3'b111, 3'b111, 3);
  endtask

  task automatic test_zero_thresholds();
    // long flag at once, zero repeat period never raises hold
    retune(16'd0, 16'd0);
    send_ticks(3'b101, 3'b000, 4);
    send_ticks(3'b111, 3'b000, 3);
  endtask

  task automatic test_lowered_thresholds();
    retune(16'd20, 16'd8);
    send_ticks(3'b011, 3'b000, 6);
    // threshold now below the running press count
    retune(16'd1, 16'd8);
    send_ticks(3'b011, 3'b000, 5);
    // repeat period now below the running repeat count
    retune(16'd1, 16'd2);
    send_ticks(3'b011, 3'b001, 3);
  endtask

  task automatic test_random_ticks();
    retune(16'd3, 16'd2);
    random_burst(70, 80);
    retune(16'hFFFF, 16'hFFFF);
    random_burst(30, 50);
    retune(16'd0, 16'd1);
    random_burst(50, 60);
    send_gap_pct = 76;
    recv_gap_pct <= 25;
    retune(CFG_BITS'($urandom_range(0, 15)), CFG_BITS'($urandom_range(1, 6)));
    random_burst(70, 60);
  endtask

  task automatic test_backpressure();
    retune(16'd5, 16'd3);
    send_gap_pct = 0;
    hold_off_len <= 60;
    hold_off_req <= ~hold_off_req;
    random_burst(30, 80);
    wait_idle();
  endtask

  task automatic test_default_timing();
    send_gap_pct = 0;
    recv_gap_pct <= 0;
    retune(bdlp_pkg::LONG_PRESS_RESET, bdlp_pkg::REPEAT_RESET);
    random_burst(120, 2);
  endtask

  initial begin
    send_gap_pct = 25;
    recv_gap_pct <= 76;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_debounce_glitch();
    test_long_press_and_hold();
    test_zero_thresholds();
    test_lowered_thresholds();
    test_random_ticks();
    test_backpressure();
    test_default_timing();
    wait_idle();
    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
